[rtl/lbm_pkg.sv]
// ----------------------------------------------------------------------------
// Layer blend mode mixer package
// Shared types, fixed-point constants and rounding and saturation helpers.
// ----------------------------------------------------------------------------
package lbm_pkg;

  localparam int FRAC      = 15;
  localparam int CH_W      = 16;
  localparam int ONE       = 1 << FRAC;
  localparam int HALF      = 1 << (FRAC - 1);
  localparam int LIMIT     = 8 * ONE;
  localparam int QBITS     = 19;
  localparam int LAT       = 24;
  localparam int ALPHA_STG = 22;

  typedef enum logic [4:0] {
    MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_SCREEN, MODE_DARKEN,
    MODE_LIGHTEN, MODE_DIFF, MODE_NEGATION, MODE_EXCL, MODE_OVERLAY,
    MODE_HARD, MODE_SOFT, MODE_DODGE, MODE_SOFT_DODGE, MODE_INV_DODGE,
    MODE_BURN, MODE_SOFT_BURN, MODE_INV_BURN, MODE_REFLECT, MODE_GLOW,
    MODE_FREEZE, MODE_HEAT, MODE_STAMP
  } blend_mode_e;

  localparam logic CFG_BLEND_MODE  = 1'b0;
  localparam logic CFG_MIX_PERCENT = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] base_red;
    logic [CH_W-1:0] base_green;
    logic [CH_W-1:0] base_blue;
    logic [CH_W-1:0] base_alpha;
    logic [CH_W-1:0] over_red;
    logic [CH_W-1:0] over_green;
    logic [CH_W-1:0] over_blue;
    logic [CH_W-1:0] over_alpha;
  } lbm_req_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
  } lbm_res_t;

  // Scales a product down by 2^FRAC, rounding half away from zero.
  function automatic logic signed [25:0] round_q(input logic signed [39:0] p);
    logic [39:0] mag;
    logic [39:0] r;
    mag = p[39] ? 40'(-p) : 40'(p);
    r   = (mag + 40'(HALF)) >> FRAC;
    return p[39] ? -$signed(26'(r)) : $signed(26'(r));
  endfunction

  // Saturates to the range of plus or minus 8.0.
  function automatic logic signed [19:0] sat_q(input logic signed [25:0] x);
    if (x > 26'sd262144) begin
      return 20'sd262144;
    end
    if (x < -26'sd262144) begin
      return -20'sd262144;
    end
    return 20'(x);
  endfunction

endpackage

[rtl/lbm_channel.sv]
// ----------------------------------------------------------------------------
// Layer blend mode mixer channel
// Blends one colour channel through a fixed 24-stage pipeline with a
// one-bit-per-stage quotient unit.
// ----------------------------------------------------------------------------
module lbm_channel import lbm_pkg::*; (
  input  logic            clk_i,
  input  logic [4:0]      mode_i,
  input  logic [CH_W-1:0] a_i,
  input  logic [CH_W-1:0] b_i,
  input  logic [17:0]     alpha_i,
  output logic [CH_W-1:0] out_o
);

  localparam logic signed [18:0] One19 = 19'(ONE);
  localparam logic signed [23:0] One24 = 24'(ONE);
  localparam logic signed [20:0] One21 = 21'(ONE);

  typedef struct packed {
    logic [36:0]      rem;
    logic [QBITS-1:0] quo;
    logic [17:0]      dmag;
    logic             neg;
    logic             inv;
    logic             ovf;
  } div_t;

  function automatic logic signed [18:0] nz(input logic signed [18:0] d);
    return (d == 19'sd0) ? One19 : d;
  endfunction

  function automatic div_t div_step(input div_t s, input int k);
    div_t        o;
    logic [36:0] sh;
    o  = s;
    sh = 37'(s.dmag) << k;
    if (s.rem >= sh) begin
      o.rem    = s.rem - sh;
      o.quo[k] = 1'b1;
    end
    return o;
  endfunction

  // Stage 1.
  logic signed [18:0] sa, sb, am, bm, px, py, dd;
  logic               lt, inv_d;
  logic signed [37:0] p1_q;
  logic [31:0]        sq_q;
  logic signed [18:0] d_q;
  logic               inv1_q;

  always_comb begin
    sa    = $signed({3'b0, a_i});
    sb    = $signed({3'b0, b_i});
    am    = One19 - sa;
    bm    = One19 - sb;
    lt    = ({1'b0, a_i} + {1'b0, b_i}) < 17'(ONE);
    px    = '0;
    py    = '0;
    dd    = One19;
    inv_d = 1'b0;
    case (mode_i) inside
      MODE_MUL: begin
        px = sa; py = sb;
      end
      MODE_SCREEN: begin
        px = am; py = bm;
      end
      MODE_EXCL, MODE_SOFT: begin
        px = sa <<< 1; py = sb;
      end
      MODE_OVERLAY: begin
        px = (a_i < 16'(HALF)) ? (sa <<< 1) : (am <<< 1);
        py = (a_i < 16'(HALF)) ? sb : bm;
      end
      MODE_HARD: begin
        px = (b_i < 16'(HALF)) ? (sa <<< 1) : (am <<< 1);
        py = (b_i < 16'(HALF)) ? sb : bm;
      end
      MODE_DIV: begin
        px = sa; py = One19; dd = nz(sb);
      end
      MODE_DODGE: begin
        px = sa; py = One19; dd = nz(bm);
      end
      MODE_SOFT_DODGE: begin
        px    = lt ? sa : bm;
        py    = One19;
        dd    = lt ? (nz(bm) <<< 1) : (nz(sa) <<< 1);
        inv_d = !lt;
      end
      MODE_INV_DODGE: begin
        px = sb; py = One19; dd = nz(am);
      end
      MODE_BURN: begin
        px = am; py = One19; dd = nz(sb); inv_d = 1'b1;
      end
      MODE_SOFT_BURN: begin
        px    = lt ? sb : am;
        py    = One19;
        dd    = lt ? (nz(am) <<< 1) : (nz(sb) <<< 1);
        inv_d = !lt;
      end
      MODE_INV_BURN: begin
        px = bm; py = One19; dd = nz(sa); inv_d = 1'b1;
      end
      MODE_REFLECT: begin
        px = sa; py = sa; dd = nz(bm);
      end
      MODE_GLOW: begin
        px = sb; py = sb; dd = nz(am);
      end
      MODE_FREEZE: begin
        px = am; py = am; dd = nz(sb); inv_d = 1'b1;
      end
      MODE_HEAT: begin
        px = bm; py = bm; dd = nz(sa); inv_d = 1'b1;
      end
      default: begin
        px = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    p1_q   <= px * py;
    sq_q   <= a_i * a_i;
    d_q    <= dd;
    inv1_q <= inv_d;
  end

  // Stage 2.
  logic signed [23:0] m1_q;
  logic [17:0]        t_q;
  logic [32:0]        nmag_q;
  logic [17:0]        dmag_q;
  logic               neg_q, ovf_q, inv2_q;
  logic [32:0]        nmag_d;
  logic [17:0]        dmag_d;

  always_comb begin
    nmag_d = 33'(p1_q[37] ? -p1_q : p1_q);
    dmag_d = 18'(d_q[18] ? -d_q : d_q);
  end

  always_ff @(posedge clk_i) begin
    m1_q   <= 24'(round_q(40'(p1_q)));
    t_q    <= 18'((33'(sq_q) + 33'(HALF)) >> FRAC);
    nmag_q <= nmag_d;
    dmag_q <= dmag_d;
    neg_q  <= p1_q[37] ^ d_q[18];
    ovf_q  <= 38'(nmag_d) >= (38'(dmag_d) << QBITS);
    inv2_q <= inv1_q;
  end

  // Channel inputs ride alongside the arithmetic.
  logic [CH_W-1:0] a_dly_q [23];
  logic [CH_W-1:0] b_dly_q [3];

  always_ff @(posedge clk_i) begin
    a_dly_q[0] <= a_i;
    b_dly_q[0] <= b_i;
    for (int i = 1; i < 23; i++) begin
      a_dly_q[i] <= a_dly_q[i-1];
    end
    for (int i = 1; i < 3; i++) begin
      b_dly_q[i] <= b_dly_q[i-1];
    end
  end

  // Stage 3 and the quotient pipeline.
  logic [34:0]        p2_q;
  logic signed [23:0] m1b_q;
  logic [17:0]        t2_q;
  div_t               div_init;
  div_t               div_q [QBITS];

  always_comb begin
    div_init.rem  = ovf_q ? '0 : 37'(nmag_q);
    div_init.quo  = '0;
    div_init.dmag = dmag_q;
    div_init.neg  = neg_q;
    div_init.inv  = inv2_q;
    div_init.ovf  = ovf_q;
  end

  always_ff @(posedge clk_i) begin
    p2_q      <= {t_q, 1'b0} * b_dly_q[1];
    m1b_q     <= m1_q;
    t2_q      <= t_q;
    div_q[0]  <= div_step(div_init, QBITS - 1);
    for (int j = 1; j < QBITS; j++) begin
      div_q[j] <= div_step(div_q[j-1], QBITS - 1 - j);
    end
  end

  // Stage 4: value of the modes that need no quotient.
  logic signed [23:0] xa, xb, m2, vn;
  logic signed [19:0] vnd_dly_q [18];

  always_comb begin
    xa = $signed({8'b0, a_dly_q[2]});
    xb = $signed({8'b0, b_dly_q[2]});
    m2 = 24'(round_q($signed(40'(p2_q))));
    case (mode_i) inside
      MODE_ADD:      vn = xa + xb;
      MODE_SUB:      vn = xa + xb - One24;
      MODE_MUL:      vn = m1b_q;
      MODE_SCREEN:   vn = One24 - m1b_q;
      MODE_DARKEN:   vn = (xa < xb) ? xa : xb;
      MODE_LIGHTEN:  vn = (xa > xb) ? xa : xb;
      MODE_DIFF:     vn = (xa > xb) ? (xa - xb) : (xb - xa);
      MODE_NEGATION: begin
        vn = One24 - xa - xb;
        vn = One24 - ((vn < 0) ? -vn : vn);
      end
      MODE_EXCL:     vn = xa + xb - m1b_q;
      MODE_OVERLAY:  vn = (a_dly_q[2] < 16'(HALF)) ? m1b_q : (One24 - m1b_q);
      MODE_HARD:     vn = (b_dly_q[2] < 16'(HALF)) ? m1b_q : (One24 - m1b_q);
      MODE_SOFT:     vn = m1b_q + $signed({6'b0, t2_q}) - m2;
      MODE_STAMP:    vn = xa + (xb <<< 1) - One24;
      default:       vn = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    vnd_dly_q[0] <= sat_q(26'(vn));
    for (int i = 1; i < 18; i++) begin
      vnd_dly_q[i] <= vnd_dly_q[i-1];
    end
  end

  // Stage 22: select value and take the difference to the base.
  logic               is_div;
  logic [QBITS-1:0]   qmag;
  logic signed [20:0] qs, vdv, vsel, diff_d;
  logic signed [20:0] diff_q;
  div_t               dl;

  always_comb begin
    dl = div_q[QBITS-1];
    case (mode_i) inside
      MODE_DIV, MODE_DODGE, MODE_SOFT_DODGE, MODE_INV_DODGE, MODE_BURN,
      MODE_SOFT_BURN, MODE_INV_BURN, MODE_REFLECT, MODE_GLOW, MODE_FREEZE,
      MODE_HEAT: is_div = 1'b1;
      default:   is_div = 1'b0;
    endcase
    qmag   = (dl.ovf || dl.quo > QBITS'(LIMIT)) ? QBITS'(LIMIT) : dl.quo;
    qs     = dl.neg ? -$signed(21'(qmag)) : $signed(21'(qmag));
    vdv    = dl.inv ? (One21 - qs) : qs;
    vsel   = is_div ? 21'(sat_q(26'(vdv))) : 21'(vnd_dly_q[17]);
    diff_d = vsel - $signed({5'b0, a_dly_q[20]});
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
  end

  // Stages 23 and 24: weight by alpha, add to the base and clamp.
  logic signed [39:0] p3_q;
  logic signed [26:0] r;
  logic [CH_W-1:0]    out_d, out_q;

  always_comb begin
    r = 27'(round_q(p3_q)) + $signed({11'b0, a_dly_q[22]});
    if (mode_i > 5'(MODE_STAMP) || r < 0) begin
      out_d = '0;
    end else if (r > 27'(ONE)) begin
      out_d = CH_W'(ONE);
    end else begin
      out_d = r[CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    p3_q  <= $signed({1'b0, alpha_i}) * diff_q;
    out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

[rtl/layer_blend_mode_mixer_top.sv]
// ----------------------------------------------------------------------------
// Layer blend mode mixer
// Blends an overlay pixel onto a base pixel in one of 24 modes, weighted by
// overlay alpha times the mix percent.
//
// Channel   | Signals                          | Direction
// request   | start_i, busy_o, req_i           | in
// result    | done_o, res_o                    | out
// config    | cfg_we_i, cfg_idx_i, cfg_wdata_i | in
//
// One request is taken every cycle; busy_o stays low.
// Each result runs through two product stages, the 19-stage quotient pipeline
// and three mixing stages.
// Reset clears the valid chain and loads the register reset values.
// The receiver cannot stall, so done_o is a single-cycle strobe.
// ----------------------------------------------------------------------------
module layer_blend_mode_mixer_top import lbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  lbm_req_t    req_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        done_o,
  output lbm_res_t    res_o
);

  logic [4:0]      mode_q;
  logic [15:0]     mix_q;
  logic            acc;
  logic [LAT-1:0]  vld_q;
  logic [31:0]     aprod_q;
  logic [17:0]     alpha_q [ALPHA_STG-1];
  logic [CH_W-1:0] ba_q [LAT];
  logic [CH_W-1:0] red, green, blue;

  assign busy_o = 1'b0;
  assign acc    = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 5'(MODE_ADD);
      mix_q  <= 16'(ONE);
      vld_q  <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_BLEND_MODE) begin
        mode_q <= cfg_wdata_i[4:0];
      end
      if (cfg_we_i && cfg_idx_i == CFG_MIX_PERCENT) begin
        mix_q <= cfg_wdata_i;
      end
      vld_q <= {vld_q[LAT-2:0], acc};
    end
  end

  always_ff @(posedge clk_i) begin
    aprod_q    <= req_i.over_alpha * mix_q;
    alpha_q[0] <= 18'(round_q($signed(40'(aprod_q))));
    for (int i = 1; i < ALPHA_STG - 1; i++) begin
      alpha_q[i] <= alpha_q[i-1];
    end
    ba_q[0] <= req_i.base_alpha;
    for (int i = 1; i < LAT; i++) begin
      ba_q[i] <= ba_q[i-1];
    end
  end

  lbm_channel u_red (
    .clk_i   (clk_i),
    .mode_i  (mode_q),
    .a_i     (req_i.base_red),
    .b_i     (req_i.over_red),
    .alpha_i (alpha_q[ALPHA_STG-2]),
    .out_o   (red)
  );

  lbm_channel u_green (
    .clk_i   (clk_i),
    .mode_i  (mode_q),
    .a_i     (req_i.base_green),
    .b_i     (req_i.over_green),
    .alpha_i (alpha_q[ALPHA_STG-2]),
    .out_o   (green)
  );

  lbm_channel u_blue (
    .clk_i   (clk_i),
    .mode_i  (mode_q),
    .a_i     (req_i.base_blue),
    .b_i     (req_i.over_blue),
    .alpha_i (alpha_q[ALPHA_STG-2]),
    .out_o   (blue)
  );

  assign done_o          = vld_q[LAT-1];
  assign res_o.out_red   = red;
  assign res_o.out_green = green;
  assign res_o.out_blue  = blue;
  assign res_o.out_alpha = ba_q[LAT-1];

endmodule

[tb/tb_layer_blend_mode_mixer_top.sv]
// ----------------------------------------------------------------------------
// Layer blend mode mixer testbench
// Streams base and overlay pixel pairs through the mixer under every blend
// mode, including the unused codes, and a range of mix percents. A built-in
// fixed-point predictor computes each blended pixel when its request is
// taken, and the monitor compares every result strobe against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_layer_blend_mode_mixer_top;
  import lbm_pkg::*;

  localparam longint QONE = 64'sd32768;
  localparam longint QSAT = 8 * QONE;
  localparam int WDOG_MAX = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  lbm_req_t    req_i;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        done_o;
  lbm_res_t    res_o;

  layer_blend_mode_mixer_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .req_i(req_i), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .done_o(done_o), .res_o(res_o)
  );

  logic [4:0]  mode_cfg;
  logic [15:0] pct_cfg;
  lbm_req_t    pixel_q[$];
  lbm_res_t    blend_exp_q[$];
  int          burst_left;
  int          gap_left;
  int          n_taken;
  int          n_checked;
  int          n_errors;
  int          idle_cycles;
  bit          modes_seen[32];

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic longint clip8(input longint x);
    if (x > QSAT) begin
      return QSAT;
    end
    if (x < -QSAT) begin
      return -QSAT;
    end
    return x;
  endfunction

  function automatic longint qmul(input longint x, input longint y);
    longint p;
    longint m;
    p = x * y;
    m = (p < 0) ? -p : p;
    m = (m + 16384) >>> 15;
    return (p < 0) ? -m : m;
  endfunction

  function automatic longint nonzero(input longint d);
    return (d != 0) ? d : QONE;
  endfunction

  function automatic longint qdiv(input longint n, input longint d);
    return clip8((n * QONE) / d);
  endfunction

  function automatic longint qdivsq(input longint x, input longint d);
    return clip8((x * x) / d);
  endfunction

  function automatic logic [15:0] blend_channel(input logic [15:0] ain,
                                                input logic [15:0] bin,
                                                input longint alpha);
    longint a;
    longint b;
    longint v;
    longint t;
    longint r;
    a = longint'(ain);
    b = longint'(bin);
    case (mode_cfg)
      MODE_ADD:        v = a + b;
      MODE_SUB:        v = a + b - QONE;
      MODE_MUL:        v = qmul(a, b);
      MODE_DIV:        v = qdiv(a, nonzero(b));
      MODE_SCREEN:     v = QONE - qmul(QONE - a, QONE - b);
      MODE_DARKEN:     v = (a < b) ? a : b;
      MODE_LIGHTEN:    v = (a > b) ? a : b;
      MODE_DIFF:       v = (a > b) ? a - b : b - a;
      MODE_NEGATION: begin
        t = QONE - a - b;
        v = QONE - ((t < 0) ? -t : t);
      end
      MODE_EXCL:       v = a + b - qmul(2 * a, b);
      MODE_OVERLAY:
        v = (a < QONE / 2) ? qmul(2 * a, b) : QONE - qmul(2 * (QONE - a), QONE - b);
      MODE_HARD:
        v = (b < QONE / 2) ? qmul(2 * a, b) : QONE - qmul(2 * (QONE - a), QONE - b);
      MODE_SOFT: begin
        t = qmul(a, a);
        v = qmul(2 * a, b) + t - qmul(2 * t, b);
      end
      MODE_DODGE:      v = qdiv(a, nonzero(QONE - b));
      MODE_SOFT_DODGE:
        v = (a + b < QONE) ? qdiv(a, 2 * nonzero(QONE - b))
                           : QONE - qdiv(QONE - b, 2 * nonzero(a));
      MODE_INV_DODGE:  v = qdiv(b, nonzero(QONE - a));
      MODE_BURN:       v = QONE - qdiv(QONE - a, nonzero(b));
      MODE_SOFT_BURN:
        v = (a + b < QONE) ? qdiv(b, 2 * nonzero(QONE - a))
                           : QONE - qdiv(QONE - a, 2 * nonzero(b));
      MODE_INV_BURN:   v = QONE - qdiv(QONE - b, nonzero(a));
      MODE_REFLECT:    v = qdivsq(a, nonzero(QONE - b));
      MODE_GLOW:       v = qdivsq(b, nonzero(QONE - a));
      MODE_FREEZE:     v = QONE - qdivsq(QONE - a, nonzero(b));
      MODE_HEAT:       v = QONE - qdivsq(QONE - b, nonzero(a));
      MODE_STAMP:      v = a + 2 * b - QONE;
      default:         return 16'd0;
    endcase
    v = clip8(v);
    r = a + qmul(alpha, v - a);
    if (r < 0) begin
      r = 0;
    end
    if (r > QONE) begin
      r = QONE;
    end
    return r[15:0];
  endfunction

  function automatic lbm_res_t blend_pixel(input lbm_req_t px);
    lbm_res_t res;
    longint alpha;
    alpha = qmul(longint'(px.over_alpha), longint'(pct_cfg));
    res.out_red   = blend_channel(px.base_red, px.over_red, alpha);
    res.out_green = blend_channel(px.base_green, px.over_green, alpha);
    res.out_blue  = blend_channel(px.base_blue, px.over_blue, alpha);
    res.out_alpha = px.base_alpha;
    return res;
  endfunction

  function automatic logic [15:0] rand_chan();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      return 16'($urandom_range(0, 32768));
    end else if (sel < 85) begin
      case ($urandom_range(0, 5))
        0: return 16'd0;
        1: return 16'd16383;
        2: return 16'd16384;
        3: return 16'd32767;
        4: return 16'd32768;
        default: return 16'd1;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic lbm_req_t rand_pixel();
    lbm_req_t px;
    px.base_red   = rand_chan();
    px.base_green = rand_chan();
    px.base_blue  = rand_chan();
    px.base_alpha = rand_chan();
    px.over_red   = rand_chan();
    px.over_green = rand_chan();
    px.over_blue  = rand_chan();
    px.over_alpha = rand_chan();
    // Green base plus overlay sums that land exactly on 1.0 exercise the soft dodge and burn split.
    if ($urandom_range(0, 5) == 0 && px.base_green <= 16'd32768) begin
      px.over_green = 16'd32768 - px.base_green;
    end
    return px;
  endfunction

  function automatic lbm_req_t make_pixel(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] oa);
    lbm_req_t px;
    px = '{a, b, a ^ b, a, b, a, 16'd32768 - (b & 16'h7FFF), oa};
    return px;
  endfunction

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BLEND_MODE) begin
      mode_cfg = val[4:0];
    end else begin
      pct_cfg = val;
    end
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || start_i || blend_exp_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic queue_directed();
    pixel_q.push_back(make_pixel(16'd0, 16'd0, 16'd32768));
    pixel_q.push_back(make_pixel(16'd32768, 16'd32768, 16'd32768));
    pixel_q.push_back(make_pixel(16'd0, 16'd32768, 16'd32768));
    pixel_q.push_back(make_pixel(16'd32768, 16'd0, 16'd32768));
    pixel_q.push_back(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF));
    pixel_q.push_back(make_pixel(16'd16383, 16'd16384, 16'd32768));
    pixel_q.push_back(make_pixel(16'd16384, 16'd16383, 16'd16384));
    pixel_q.push_back(make_pixel(16'd10000, 16'd22768, 16'd32768));
    pixel_q.push_back(make_pixel(16'd1, 16'd32767, 16'd0));
    pixel_q.push_back(make_pixel(16'h8001, 16'h5555, 16'hAAAA));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i    <= 1'b0;
      req_i      <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (start_i && !busy_o) begin
        blend_exp_q.push_back(blend_pixel(req_i));
        modes_seen[mode_cfg] = 1'b1;
        n_taken++;
      end
      if (start_i && busy_o) begin
        start_i <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i  <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        start_i <= 1'b1;
        req_i   <= pixel_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || cfg_we_i) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WDOG_MAX) begin
        $display("*** FAILED ***");
        $finish;
      end
      if (done_o) begin
        if (blend_exp_q.size() == 0) begin
          $error("unexpected result %h", res_o);
          n_errors++;
        end else begin
          lbm_res_t want;
          want = blend_exp_q.pop_front();
          n_checked++;
          if (res_o.out_red !== want.out_red) begin
            $error("out_red expected %0d got %0d", want.out_red, res_o.out_red);
            n_errors++;
          end
          if (res_o.out_green !== want.out_green) begin
            $error("out_green expected %0d got %0d", want.out_green, res_o.out_green);
            n_errors++;
          end
          if (res_o.out_blue !== want.out_blue) begin
            $error("out_blue expected %0d got %0d", want.out_blue, res_o.out_blue);
            n_errors++;
          end
          if (res_o.out_alpha !== want.out_alpha) begin
            $error("out_alpha expected %0d got %0d", want.out_alpha, res_o.out_alpha);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    logic [15:0] pct_pick;
    int n_modes;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = 1'b0;
    cfg_wdata_i = '0;
    mode_cfg    = 5'd0;
    pct_cfg     = 16'd32768;
    n_taken     = 0;
    n_checked   = 0;
    n_errors    = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values first, then every mode code with the directed pixels.
    queue_directed();
    drain();
    for (int m = 0; m < 32; m++) begin
      write_reg(CFG_BLEND_MODE, 16'(m) | (16'($urandom) & 16'hFFE0));
      write_reg(CFG_MIX_PERCENT, (m % 3 == 0) ? 16'd32768 :
                                 (m % 3 == 1) ? 16'hFFFF : 16'd0);
      queue_directed();
      drain();
    end

    for (int ph = 0; ph < 40; ph++) begin
      case ($urandom_range(0, 5))
        0: pct_pick = 16'd0;
        1: pct_pick = 16'd32768;
        2: pct_pick = 16'hFFFF;
        default: pct_pick = 16'($urandom_range(0, 32768));
      endcase
      write_reg(CFG_MIX_PERCENT, pct_pick);
      write_reg(CFG_BLEND_MODE, ($urandom_range(0, 9) == 0) ?
                16'($urandom_range(24, 31)) : 16'($urandom_range(0, 23)));
      for (int k = 0; k < 27; k++) begin
        pixel_q.push_back(rand_pixel());
      end
      drain();
    end

    repeat (LAT + 10) @(posedge clk_i);
    n_modes = 0;
    for (int m = 0; m < 32; m++) begin
      n_modes += modes_seen[m];
    end
    $display("Blended %0d pixel pairs, %0d results checked, %0d mode codes used.",
             n_taken, n_checked, n_modes);
    if (n_errors == 0 && blend_exp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lbm_pkg.sv
rtl/lbm_channel.sv
rtl/layer_blend_mode_mixer_top.sv
tb/tb_layer_blend_mode_mixer_top.sv
